/* rtl/sparse_set_id_table_defines.svh */
// Assertion macros for the sparse set id table.
`ifndef SPARSE_SET_ID_TABLE_DEFINES_SVH
`define SPARSE_SET_ID_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define SSIT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSIT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);
`else
`define SSIT_ASSERT(label, clk, rst_n, prop, msg)
`define SSIT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

/* rtl/ssit_pkg.sv */
package ssit_pkg;
	localparam int MaxIds = 256;
	localparam int IdW = 8;
	localparam int CntW = 9;
	localparam int PayW = 32;
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_READ_ID = 2'd2;
	localparam logic [1:0] OP_READ_SLOT = 2'd3;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [IdW-1:0] entry_id;
		logic [IdW-1:0] slot_index;
		logic [PayW-1:0] payload;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [IdW-1:0] result_id;
		logic [IdW-1:0] result_slot;
		logic [PayW-1:0] result_payload;
		logic [CntW-1:0] live_count;
	} rsp_t;
endpackage

/* rtl/ssit_front.sv */
module ssit_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ssit_pkg::cmd_t in_cmd,
	output logic q_valid,
	input logic q_ready,
	output ssit_pkg::cmd_t q_cmd
);
	import ssit_pkg::*;

	cmd_t buf_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			buf_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				wr_q <= ~wr_q;
			end
			if (q_valid && q_ready) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule

/* rtl/ssit_back.sv */
module ssit_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ssit_pkg::CntW-1:0] cfg_data,
	input logic q_valid,
	output logic q_ready,
	input ssit_pkg::cmd_t q_cmd,
	output logic out_valid,
	input logic out_ready,
	output ssit_pkg::rsp_t out_rsp
);
	import ssit_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOK = 3'd1;
	localparam logic [2:0] S_MOVE = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;
	localparam logic [2:0] S_FILL = 3'd4;

	logic [IdW-1:0] map_mem [MaxIds];
	logic [IdW-1:0] dense_id_mem [MaxIds];
	logic [PayW-1:0] dense_pay_mem [MaxIds];
	logic [IdW-1:0] fifo_mem [MaxIds];
	logic [MaxIds-1:0] live_q;

	logic [2:0] state_q;
	cmd_t cmd_q;
	logic [CntW-1:0] limit_q, dense_q, free_cnt_q, fill_q;
	logic [IdW-1:0] head_q, tail_q;
	logic [IdW-1:0] slot_q, last_id_q, fifo_rd_q, map_rd_q, did_rd_q;
	logic [PayW-1:0] pay_rd_q, last_pay_q;
	rsp_t rsp_q, out_q, rsp_next, done_rsp;
	logic ov_q;

	logic [CntW-1:0] lim_sat;
	logic [IdW-1:0] last_slot;
	logic id_bad;
	logic emit;
	assign lim_sat = (cfg_data > CntW'(MaxIds)) ? CntW'(MaxIds) : cfg_data;
	assign last_slot = IdW'(dense_q - 1'b1);
	assign id_bad = ({1'b0, cmd_q.entry_id} >= limit_q) || !live_q[cmd_q.entry_id]
		|| ({1'b0, map_rd_q} >= dense_q);
	assign emit = (state_q == S_DONE) && !cfg_we && (!ov_q || out_ready);

	assign q_ready = (state_q == S_IDLE) && !cfg_we;
	assign out_valid = ov_q;
	assign out_rsp = out_q;

	always_comb begin
		rsp_next = rsp_q;
		case (state_q)
			S_LOOK: begin
				rsp_next = '0;
				rsp_next.live_count = dense_q;
				case (cmd_q.opcode)
					OP_ADD: begin
						if (free_cnt_q == '0) begin
							rsp_next.status = ST_FULL;
						end else begin
							rsp_next.result_id = fifo_rd_q;
							rsp_next.result_slot = dense_q[IdW-1:0];
							rsp_next.live_count = dense_q + 1'b1;
						end
					end
					OP_READ_SLOT: begin
						if ({1'b0, cmd_q.slot_index} >= dense_q) begin
							rsp_next.status = ST_ABSENT;
						end else begin
							rsp_next.result_id = did_rd_q;
							rsp_next.result_slot = cmd_q.slot_index;
							rsp_next.result_payload = pay_rd_q;
						end
					end
					default: begin
						if (id_bad) begin
							rsp_next.status = ST_ABSENT;
						end else begin
							rsp_next.result_id = cmd_q.entry_id;
							rsp_next.result_slot = map_rd_q;
						end
					end
				endcase
			end
			S_MOVE: begin
				rsp_next.result_payload = pay_rd_q;
				rsp_next.live_count = dense_q - 1'b1;
			end
			default: rsp_next = rsp_q;
		endcase
	end

	always_comb begin
		done_rsp = rsp_q;
		if (cmd_q.opcode == OP_READ_ID && rsp_q.status == ST_OK) begin
			done_rsp.result_payload = pay_rd_q;
		end
	end

	// Memory ports: registered reads issued in the idle cycle and the look cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			map_rd_q <= map_mem[q_cmd.entry_id];
			fifo_rd_q <= fifo_mem[head_q];
			did_rd_q <= dense_id_mem[q_cmd.slot_index];
			pay_rd_q <= dense_pay_mem[q_cmd.slot_index];
			last_id_q <= dense_id_mem[last_slot];
			last_pay_q <= dense_pay_mem[last_slot];
		end else if (state_q == S_LOOK) begin
			pay_rd_q <= dense_pay_mem[map_rd_q];
		end
		if (state_q == S_FILL) begin
			fifo_mem[fill_q[IdW-1:0]] <= fill_q[IdW-1:0];
		end else if (state_q == S_LOOK && cmd_q.opcode == OP_ADD && free_cnt_q != '0) begin
			dense_id_mem[dense_q[IdW-1:0]] <= fifo_rd_q;
			dense_pay_mem[dense_q[IdW-1:0]] <= cmd_q.payload;
			map_mem[fifo_rd_q] <= dense_q[IdW-1:0];
		end else if (state_q == S_MOVE) begin
			fifo_mem[tail_q] <= cmd_q.entry_id;
			if (slot_q != last_slot) begin
				dense_id_mem[slot_q] <= last_id_q;
				dense_pay_mem[slot_q] <= last_pay_q;
				map_mem[last_id_q] <= slot_q;
			end
		end
		if (state_q == S_IDLE && q_valid) begin
			cmd_q <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			limit_q <= CntW'(MaxIds);
			fill_q <= '0;
			dense_q <= '0;
			free_cnt_q <= CntW'(MaxIds);
			head_q <= '0;
			tail_q <= '0;
			live_q <= '0;
			ov_q <= 1'b0;
			slot_q <= '0;
			rsp_q <= '0;
			out_q <= '0;
		end else begin
			rsp_q <= rsp_next;
			if (emit) begin
				ov_q <= 1'b1;
				out_q <= done_rsp;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (cfg_we) begin
				state_q <= S_FILL;
				limit_q <= lim_sat;
				fill_q <= '0;
				dense_q <= '0;
				free_cnt_q <= lim_sat;
				head_q <= '0;
				tail_q <= lim_sat[IdW-1:0];
				live_q <= '0;
			end else begin
				case (state_q)
					S_FILL: begin
						fill_q <= fill_q + 1'b1;
						if (fill_q == CntW'(MaxIds - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (q_valid) begin
							state_q <= S_LOOK;
						end
					end
					S_LOOK: begin
						state_q <= S_DONE;
						case (cmd_q.opcode)
							OP_ADD: begin
								if (free_cnt_q != '0) begin
									head_q <= head_q + 1'b1;
									free_cnt_q <= free_cnt_q - 1'b1;
									live_q[fifo_rd_q] <= 1'b1;
									dense_q <= dense_q + 1'b1;
								end
							end
							OP_READ_SLOT: begin
								state_q <= S_DONE;
							end
							default: begin
								if (!id_bad) begin
									slot_q <= map_rd_q;
									state_q <= (cmd_q.opcode == OP_REMOVE) ? S_MOVE : S_DONE;
								end
							end
						endcase
					end
					S_MOVE: begin
						live_q[cmd_q.entry_id] <= 1'b0;
						tail_q <= tail_q + 1'b1;
						free_cnt_q <= free_cnt_q + 1'b1;
						dense_q <= dense_q - 1'b1;
						state_q <= S_DONE;
					end
					S_DONE: begin
						if (!ov_q || out_ready) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end
endmodule

/* rtl/sparse_set_id_table.sv */
// Sparse-set id table: add hands out ids from a free queue, remove compacts the dense
// array, and reads look up an entry by id or by dense slot. A back-end item passes the
// idle, look and done states (a remove also the move state), as the reads and writes
// of the map, dense and free-queue memories depend on one another. A two-deep queue
// parts the input from the back end and the output register holds one result. After
// reset and each cfg_we write all 256 free-queue entries refill before items are taken.
module sparse_set_id_table (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [8:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// opcode[1:0], entry_id[9:2], slot_index[17:10], payload[49:18], zeros above.
	input logic [55:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// status[1:0], result_id[9:2], result_slot[17:10], result_payload[49:18],
	// live_count[58:50], zeros above.
	output logic [63:0] m_tdata
);
	import ssit_pkg::*;
	`include "sparse_set_id_table_defines.svh"

	cmd_t in_cmd, q_cmd;
	rsp_t rsp;
	logic q_valid, q_ready;

	assign in_cmd.opcode = s_tdata[1:0];
	assign in_cmd.entry_id = s_tdata[9:2];
	assign in_cmd.slot_index = s_tdata[17:10];
	assign in_cmd.payload = s_tdata[49:18];
	assign m_tdata = {5'd0, rsp.live_count, rsp.result_payload, rsp.result_slot,
		rsp.result_id, rsp.status};

	ssit_front u_front (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_cmd, .q_valid, .q_ready, .q_cmd);

	ssit_back u_back (.clk, .arst_n, .cfg_we, .cfg_data, .q_valid, .q_ready, .q_cmd,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_rsp(rsp));

	`SSIT_ASSERT(a_status_legal, clk, arst_n, !m_tvalid || rsp.status != 2'd3, "bad status")
	`SSIT_ASSERT(a_live_bound, clk, arst_n, !m_tvalid || rsp.live_count <= 9'd256, "live count")
	`SSIT_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "held")
endmodule
